// ===== src/mbcs_sc_pkg.sv =====
// shared types and codes for the state-table character counter
// no dependencies
package mbcs_sc_pkg;

    localparam int unsigned STATE_W  = 7;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned OFF_W    = 24;
    localparam int unsigned TOTAL_W  = 32;
    localparam int unsigned COUNT_W  = 31;
    localparam int unsigned ACTION_W = 4;
    localparam int unsigned STATUS_W = 3;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_BYTE  = 2'd1,
        FUNC_END   = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_ILLEGAL     = 3'd1,
        ST_CHANGE_ONLY = 3'd2,
        ST_RESERVED    = 3'd3,
        ST_TOO_SHORT   = 3'd4
    } status_t;

    // actions up to this code count one character
    localparam logic [ACTION_W-1:0] ACT_LAST_COUNTED = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_ILLEGAL      = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_CHANGE_ONLY  = 4'd8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // payload holds the offset of a transition, or the action in its low bits
    typedef struct packed {
        logic               is_final;
        logic [STATE_W-1:0] next_state;
        logic [OFF_W-1:0]   payload;
    } entry_t;

    typedef struct packed {
        logic               wr_en;
        logic               rd_en;
        logic [STATE_W-1:0] row;
        logic [BYTE_W-1:0]  col;
        entry_t             wdata;
    } tbl_req_t;

    typedef struct packed {
        logic  valid;
        func_t func;
        logic  oob;
    } s2_ctl_t;

    typedef struct packed {
        logic [COUNT_W-1:0] char_count;
        status_t            status;
    } walk_res_t;

endpackage

// ===== src/mbcs_sc_table.sv =====
// state table memory: one write and one registered read per cycle
// depends on mbcs_sc_pkg
module mbcs_sc_table #(
    parameter int unsigned STATE_ROWS = 128
) (
    input  logic                  clk,
    input  mbcs_sc_pkg::tbl_req_t req,
    output mbcs_sc_pkg::entry_t   rd_entry
);

    localparam int unsigned ROW_W = (STATE_ROWS > 1) ? $clog2(STATE_ROWS) : 1;
    localparam int unsigned ADDR_W = ROW_W + mbcs_sc_pkg::BYTE_W;
    localparam int unsigned DEPTH = STATE_ROWS * 256;

    mbcs_sc_pkg::entry_t mem [0:DEPTH-1];
    mbcs_sc_pkg::entry_t rd_entry_reg;
    logic [ADDR_W-1:0]   addr;

    assign addr = {req.row[ROW_W-1:0], req.col};

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rd_entry_reg <= mem[addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

// ===== src/mbcs_sc_walk.sv =====
// walk state: current state, offset total, character total, latched error
// depends on mbcs_sc_pkg
module mbcs_sc_walk (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               commit,
    input  mbcs_sc_pkg::s2_ctl_t               ctl,
    input  mbcs_sc_pkg::entry_t                entry,
    output logic [mbcs_sc_pkg::STATE_W-1:0]    cur_state_next,
    output mbcs_sc_pkg::walk_res_t             res
);

    logic [mbcs_sc_pkg::STATE_W-1:0]  state_reg, state_next;
    logic [mbcs_sc_pkg::TOTAL_W-1:0]  offset_reg, offset_next;
    logic [mbcs_sc_pkg::COUNT_W-1:0]  count_reg, count_next;
    mbcs_sc_pkg::status_t             err_reg, err_next;
    logic [mbcs_sc_pkg::ACTION_W-1:0] act;

    assign act = entry.payload[mbcs_sc_pkg::ACTION_W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        offset_next = offset_reg;
        count_next  = count_reg;
        err_next    = err_reg;
        if (ctl.valid)
        begin
            unique case (ctl.func)
                mbcs_sc_pkg::FUNC_BYTE:
                begin
                    if (err_reg == mbcs_sc_pkg::ST_OK)
                    begin
                        if (ctl.oob)
                        begin
                            err_next = mbcs_sc_pkg::ST_ILLEGAL;
                        end
                        else if (!entry.is_final)
                        begin
                            state_next  = entry.next_state;
                            offset_next = offset_reg
                                + mbcs_sc_pkg::TOTAL_W'(entry.payload);
                        end
                        else if (act <= mbcs_sc_pkg::ACT_LAST_COUNTED)
                        begin
                            if (count_reg != mbcs_sc_pkg::COUNT_MAX)
                            begin
                                count_next = count_reg + mbcs_sc_pkg::COUNT_W'(1);
                            end
                            state_next  = entry.next_state;
                            offset_next = '0;
                        end
                        else if (act == mbcs_sc_pkg::ACT_ILLEGAL)
                        begin
                            err_next = mbcs_sc_pkg::ST_ILLEGAL;
                        end
                        else if (act == mbcs_sc_pkg::ACT_CHANGE_ONLY)
                        begin
                            err_next = mbcs_sc_pkg::ST_CHANGE_ONLY;
                        end
                        else
                        begin
                            err_next = mbcs_sc_pkg::ST_RESERVED;
                        end
                    end
                end
                mbcs_sc_pkg::FUNC_END:
                begin
                    state_next  = '0;
                    offset_next = '0;
                    count_next  = '0;
                    err_next    = mbcs_sc_pkg::ST_OK;
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    // report for an end item, taken from the totals before it
    always_comb
    begin
        if (err_reg != mbcs_sc_pkg::ST_OK)
        begin
            res.status = err_reg;
        end
        else if (offset_reg != '0)
        begin
            res.status = mbcs_sc_pkg::ST_TOO_SHORT;
        end
        else
        begin
            res.status = mbcs_sc_pkg::ST_OK;
        end
        res.char_count = (res.status == mbcs_sc_pkg::ST_OK) ? count_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= '0;
            offset_reg <= '0;
            count_reg  <= '0;
            err_reg    <= mbcs_sc_pkg::ST_OK;
        end
        else if (commit)
        begin
            state_reg  <= state_next;
            offset_reg <= offset_next;
            count_reg  <= count_next;
            err_reg    <= err_next;
        end
    end

    assign cur_state_next = state_next;

endmodule

// ===== src/mbcs_state_table_char_counter_unit.sv =====
// top level of the state-table character counter
// depends on mbcs_sc_pkg, mbcs_sc_table, mbcs_sc_walk
//
// Counts the characters of a multibyte byte sequence by walking a state
// table of STATE_ROWS rows by 256 byte columns. Table entries are loaded
// with func write, data bytes are walked with func byte, and func end
// produces one result (character count and status) and restarts the walk
// at state 0. The block takes one item per clock while in_stall is low: the only
// loop is one table read per byte, whose address is formed from the entry
// read for the byte before, closed through the table's registered read
// port and the walk's combinational next-state logic. An end item passes the input
// register and the second-stage control register before its result reaches the
// output register. The input is stalled only while an end item is ready
// to report and an earlier result still waits on a stalled output. The
// table has no reset and needs no clearing pass: every entry must be written
// before a walk reads it, otherwise the result of that walk is meaningless.
module mbcs_state_table_char_counter_unit #(
    parameter int unsigned STATE_ROWS = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [7:0]  cell_byte,
    input  logic [6:0]  write_row,
    input  logic        write_is_final,
    input  logic [6:0]  write_next_state,
    input  logic [3:0]  write_action,
    input  logic [23:0] write_offset,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [30:0] char_count,
    output logic [2:0]  status
);

    // first stage: input register
    logic                                s1_valid_reg;
    mbcs_sc_pkg::func_t                  s1_func_reg;
    logic [mbcs_sc_pkg::BYTE_W-1:0]      s1_cell_reg;
    logic [mbcs_sc_pkg::STATE_W-1:0]     s1_row_reg;
    logic                                s1_fin_reg;
    logic [mbcs_sc_pkg::STATE_W-1:0]     s1_next_reg;
    logic [mbcs_sc_pkg::ACTION_W-1:0]    s1_act_reg;
    logic [mbcs_sc_pkg::OFF_W-1:0]       s1_off_reg;

    // second stage: control alongside the registered table read
    mbcs_sc_pkg::s2_ctl_t                s2_ctl_reg, s2_ctl_next;

    // output register
    logic                                out_valid_reg;
    logic [mbcs_sc_pkg::COUNT_W-1:0]     char_count_reg;
    mbcs_sc_pkg::status_t                status_reg;

    logic                                adv;
    logic                                s2_is_end;
    logic [mbcs_sc_pkg::STATE_W-1:0]     walk_state;
    logic                                walk_oob;
    logic                                row_ok;
    mbcs_sc_pkg::tbl_req_t               tbl_req;
    mbcs_sc_pkg::entry_t                 tbl_entry;
    mbcs_sc_pkg::walk_res_t              walk_res;

    // the pipeline freezes only when an end item would overwrite a waiting result
    assign s2_is_end = s2_ctl_reg.valid && (s2_ctl_reg.func == mbcs_sc_pkg::FUNC_END);
    assign adv       = !(s2_is_end && out_valid_reg && out_stall);
    assign in_stall  = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            s1_func_reg <= mbcs_sc_pkg::func_t'(func);
            s1_cell_reg <= cell_byte;
            s1_row_reg  <= write_row;
            s1_fin_reg  <= write_is_final;
            s1_next_reg <= write_next_state;
            s1_act_reg  <= write_action;
            s1_off_reg  <= write_offset;
        end
    end

    // walk_state already includes the byte now in the second stage
    assign walk_oob = {1'b0, walk_state} >= 8'(STATE_ROWS);
    assign row_ok   = {1'b0, s1_row_reg} < 8'(STATE_ROWS);

    always_comb
    begin
        tbl_req.wr_en = adv && s1_valid_reg
            && (s1_func_reg == mbcs_sc_pkg::FUNC_WRITE) && row_ok;
        tbl_req.rd_en = adv && s1_valid_reg
            && (s1_func_reg == mbcs_sc_pkg::FUNC_BYTE) && !walk_oob;
        tbl_req.row   = (s1_func_reg == mbcs_sc_pkg::FUNC_WRITE) ? s1_row_reg : walk_state;
        tbl_req.col   = s1_cell_reg;
        tbl_req.wdata.is_final   = s1_fin_reg;
        tbl_req.wdata.next_state = s1_next_reg;
        tbl_req.wdata.payload    = s1_fin_reg
            ? mbcs_sc_pkg::OFF_W'(s1_act_reg) : s1_off_reg;
    end

    mbcs_sc_table #(
        .STATE_ROWS (STATE_ROWS)
    ) u_table (
        .clk      (clk),
        .req      (tbl_req),
        .rd_entry (tbl_entry)
    );

    always_comb
    begin
        s2_ctl_next.valid = s1_valid_reg;
        s2_ctl_next.func  = s1_func_reg;
        s2_ctl_next.oob   = walk_oob;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctl_reg <= '0;
        end
        else if (adv)
        begin
            s2_ctl_reg <= s2_ctl_next;
        end
    end

    mbcs_sc_walk u_walk (
        .clk            (clk),
        .rst_n          (rst_n),
        .commit         (adv),
        .ctl            (s2_ctl_reg),
        .entry          (tbl_entry),
        .cur_state_next (walk_state),
        .res            (walk_res)
    );

    // result transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv && s2_is_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s2_is_end)
        begin
            char_count_reg <= walk_res.char_count;
            status_reg     <= walk_res.status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign char_count = char_count_reg;
    assign status     = status_reg;

endmodule
